// ===== hdl/bitmap_frame_allocator_macros.svh =====
// ---------------------------------------------------------------------------
// bitmap frame allocator assertion macros
// shared property forms used by the allocator rtl
// ---------------------------------------------------------------------------
`ifndef BITMAP_FRAME_ALLOCATOR_MACROS_SVH
`define BITMAP_FRAME_ALLOCATOR_MACROS_SVH

// same-cycle implication
`define BFA_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication
`define BFA_ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== hdl/bfa_pkg.sv =====
// ---------------------------------------------------------------------------
// bfa_pkg
// shared types and constants of the bitmap frame allocator
// ---------------------------------------------------------------------------
package bfa_pkg;

  localparam int WORD_W = 64;
  localparam int IDX_W  = 6;

  localparam logic MODE_ALLOC = 1'b0;
  localparam logic MODE_FREE  = 1'b1;

  typedef logic [IDX_W-1:0] bit_idx_t;

  typedef struct packed {
    logic     hit;
    bit_idx_t idx;
  } scan_res_t;

endpackage

// ===== hdl/bfa_ram.sv =====
// ---------------------------------------------------------------------------
// bfa_ram
// generic single write port, single read port ram with registered read
// ---------------------------------------------------------------------------
module bfa_ram #(
  parameter int WIDTH = 64,
  parameter int DEPTH = 64
) (
  input  logic                                     clk,
  input  logic                                     we,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  logic [WIDTH-1:0]                         wdata,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic [WIDTH-1:0]                         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// ===== hdl/bfa_scan.sv =====
// ---------------------------------------------------------------------------
// bfa_scan
// finds the first free run of the requested length ending in one bitmap word
// ---------------------------------------------------------------------------
module bfa_scan #(
  parameter int MAX_RUN = 256,
  parameter int RUNW    = 9
) (
  input  logic [bfa_pkg::WORD_W-1:0] used,
  input  logic [RUNW-1:0]            carry_in,
  input  logic [RUNW-1:0]            cnt,
  output bfa_pkg::scan_res_t         res,
  output logic [RUNW-1:0]            carry_out
);

  import bfa_pkg::*;

  logic [WORD_W-1:0] lu_v;
  bit_idx_t          lu_p [WORD_W];
  logic [RUNW-1:0]   run  [WORD_W];
  logic [WORD_W-1:0] hit;
  logic [RUNW-1:0]   carry_add;

  // prefix search for the last used bit at or below each lane
  always_comb begin
    for (int i = 0; i < WORD_W; i++) begin
      lu_v[i] = used[i];
      lu_p[i] = IDX_W'(i);
    end
    for (int l = 0; l < IDX_W; l++) begin
      for (int i = WORD_W - 1; i >= (1 << l); i--) begin
        if (!lu_v[i] && lu_v[i - (1 << l)]) begin
          lu_v[i] = 1'b1;
          lu_p[i] = lu_p[i - (1 << l)];
        end
      end
    end
    for (int i = 0; i < WORD_W; i++) begin
      run[i] = lu_v[i] ? RUNW'(IDX_W'(i) - lu_p[i]) : RUNW'(i + 1) + carry_in;
      hit[i] = !used[i] && (run[i] >= cnt);
    end
    res.hit = |hit;
    res.idx = '0;
    for (int i = WORD_W - 1; i >= 0; i--) begin
      if (hit[i]) begin
        res.idx = IDX_W'(i);
      end
    end
  end

  assign carry_add = carry_in + RUNW'(WORD_W);

  always_comb begin
    if (lu_v[WORD_W-1]) begin
      carry_out = RUNW'(IDX_W'(WORD_W - 1) - lu_p[WORD_W-1]);
    end else if (carry_add >= RUNW'(MAX_RUN)) begin
      carry_out = RUNW'(MAX_RUN);
    end else begin
      carry_out = carry_add;
    end
  end

endmodule

// ===== hdl/bitmap_frame_allocator.sv =====
// ---------------------------------------------------------------------------
// bitmap_frame_allocator
// first-fit page frame allocator over a bitmap held in one ram
// ---------------------------------------------------------------------------
// After reset the block runs a clearing pass that marks every frame used,
// one 64-bit bitmap word per cycle, with busy high. An allocate scans one
// bitmap word per cycle from the word holding search_start, continuing up
// to the last bitmap word. Marking or freeing a run then reads and writes
// back each bitmap word it touches in turn, at most five words for a
// 256-frame run. Rejected requests answer in the cycle after start.
// The result appears on out_ok and out_base_frame for the single cycle that
// out_valid is high; the receiver cannot stall it, and busy is already low
// in that cycle so a new request may start there.
// ---------------------------------------------------------------------------
`include "bitmap_frame_allocator_macros.svh"

module bitmap_frame_allocator #(
  parameter int FRAMES  = 4096,
  parameter int MAX_RUN = 256
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        start,
  output logic        busy,
  input  logic        in_mode,
  input  logic [11:0] in_start_frame,
  input  logic [8:0]  in_num_frames,
  output logic        out_valid,
  output logic        out_ok,
  output logic [11:0] out_base_frame,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [11:0] cfg_search_start
);

  import bfa_pkg::*;

  localparam int WORDS = (FRAMES + WORD_W - 1) / WORD_W;
  localparam int AW    = (WORDS > 1) ? $clog2(WORDS) : 1;
  localparam int FIW   = $clog2(FRAMES);
  localparam int XW    = ((FIW > 12) ? FIW : 12) + 1;
  localparam int RUNW  = $clog2(MAX_RUN + WORD_W + 1);
  localparam int TAIL  = FRAMES % WORD_W;
  localparam logic [AW-1:0] LAST = AW'(WORDS - 1);

  typedef enum logic [2:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_SCAN,
    ST_RD,
    ST_WR
  } state_t;

  state_t            state_r, state_nxt;
  logic [AW-1:0]     cur_r, cur_nxt;
  logic [AW-1:0]     wrd_r, wrd_nxt;
  logic [AW-1:0]     clr_r, clr_nxt;
  logic [RUNW-1:0]   carry_r, carry_nxt;
  logic [RUNW-1:0]   cnt_r, cnt_nxt;
  logic [XW-1:0]     lo_r, lo_nxt;
  logic [XW-1:0]     hi_r, hi_nxt;
  logic              set_r, set_nxt;
  logic [11:0]       ss_r, ss_nxt;
  logic              out_valid_r, out_valid_nxt;
  logic              out_ok_r, out_ok_nxt;
  logic [11:0]       out_base_r, out_base_nxt;

  logic              ram_we;
  logic [AW-1:0]     ram_waddr;
  logic [AW-1:0]     ram_raddr;
  logic [WORD_W-1:0] ram_wdata;
  logic [WORD_W-1:0] ram_q;

  logic [WORD_W-1:0] used_m;
  logic [WORD_W-1:0] upd_mask;
  scan_res_t         scan_res;
  logic [RUNW-1:0]   scan_carry;

  logic [AW-1:0]     ss_word;
  logic [AW-1:0]     lo_word;
  logic [AW-1:0]     hi_word;
  logic              cnt_ok;
  logic              ss_ok;
  logic              fr_beyond;
  logic [XW-1:0]     fr_end;
  logic [XW-1:0]     fr_hi;
  logic [XW-1:0]     hit_frame;
  logic [XW-1:0]     hit_base;
  bit_idx_t          lob;
  bit_idx_t          hib;

  bfa_ram #(
    .WIDTH (WORD_W),
    .DEPTH (WORDS)
  ) u_bitmap (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .raddr (ram_raddr),
    .rdata (ram_q)
  );

  bfa_scan #(
    .MAX_RUN (MAX_RUN),
    .RUNW    (RUNW)
  ) u_scan (
    .used      (used_m),
    .carry_in  (carry_r),
    .cnt       (cnt_r),
    .res       (scan_res),
    .carry_out (scan_carry)
  );

  assign ss_word   = AW'(ss_r >> IDX_W);
  assign lo_word   = AW'(lo_r >> IDX_W);
  assign hi_word   = AW'(hi_r >> IDX_W);
  assign cnt_ok    = (in_num_frames != '0) && (32'(in_num_frames) <= MAX_RUN);
  assign ss_ok     = 32'(ss_r) < FRAMES;
  assign fr_beyond = 32'(in_start_frame) >= FRAMES;
  assign fr_end    = XW'(in_start_frame) + XW'(in_num_frames) - XW'(1);
  assign fr_hi     = (fr_end > XW'(FRAMES - 1)) ? XW'(FRAMES - 1) : fr_end;
  assign hit_frame = XW'({cur_r, scan_res.idx});
  assign hit_base  = hit_frame - XW'(cnt_r) + XW'(1);
  assign lob       = (wrd_r == lo_word) ? lo_r[IDX_W-1:0] : '0;
  assign hib       = (wrd_r == hi_word) ? hi_r[IDX_W-1:0] : '1;

  // frames below search_start and past the bitmap end count as used
  always_comb begin
    for (int i = 0; i < WORD_W; i++) begin
      used_m[i] = ram_q[i]
                | ((cur_r == ss_word) && (IDX_W'(i) < ss_r[IDX_W-1:0]))
                | ((cur_r == LAST) && (TAIL != 0) && (i >= TAIL));
      upd_mask[i] = (IDX_W'(i) >= lob) && (IDX_W'(i) <= hib);
    end
  end

  always_comb begin
    state_nxt     = state_r;
    cur_nxt       = cur_r;
    wrd_nxt       = wrd_r;
    clr_nxt       = clr_r;
    carry_nxt     = carry_r;
    cnt_nxt       = cnt_r;
    lo_nxt        = lo_r;
    hi_nxt        = hi_r;
    set_nxt       = set_r;
    ss_nxt        = cfg_valid ? cfg_search_start : ss_r;
    out_valid_nxt = 1'b0;
    out_ok_nxt    = out_ok_r;
    out_base_nxt  = out_base_r;
    ram_we        = 1'b0;
    ram_waddr     = wrd_r;
    ram_wdata     = set_r ? (ram_q | upd_mask) : (ram_q & ~upd_mask);
    ram_raddr     = ss_word;
    case (state_r)
      ST_CLEAR: begin
        ram_we    = 1'b1;
        ram_waddr = clr_r;
        ram_wdata = '1;
        clr_nxt   = clr_r + AW'(1);
        if (clr_r == LAST) begin
          state_nxt = ST_IDLE;
        end
      end
      ST_IDLE: begin
        if (start) begin
          cnt_nxt   = RUNW'(in_num_frames);
          carry_nxt = '0;
          cur_nxt   = ss_word;
          set_nxt   = (in_mode == MODE_ALLOC);
          if (!cnt_ok || ((in_mode == MODE_ALLOC) && !ss_ok)) begin
            out_valid_nxt = 1'b1;
            out_ok_nxt    = 1'b0;
            out_base_nxt  = '0;
          end else if (in_mode == MODE_ALLOC) begin
            state_nxt = ST_SCAN;
          end else if (fr_beyond) begin
            out_valid_nxt = 1'b1;
            out_ok_nxt    = 1'b1;
            out_base_nxt  = '0;
          end else begin
            lo_nxt    = XW'(in_start_frame);
            hi_nxt    = fr_hi;
            wrd_nxt   = AW'(in_start_frame >> IDX_W);
            state_nxt = ST_RD;
          end
        end
      end
      ST_SCAN: begin
        ram_raddr = (cur_r == LAST) ? cur_r : cur_r + AW'(1);
        if (scan_res.hit) begin
          lo_nxt    = hit_base;
          hi_nxt    = hit_frame;
          wrd_nxt   = AW'(hit_base >> IDX_W);
          state_nxt = ST_RD;
        end else if (cur_r == LAST) begin
          out_valid_nxt = 1'b1;
          out_ok_nxt    = 1'b0;
          out_base_nxt  = '0;
          state_nxt     = ST_IDLE;
        end else begin
          cur_nxt   = cur_r + AW'(1);
          carry_nxt = scan_carry;
        end
      end
      ST_RD: begin
        ram_raddr = wrd_r;
        state_nxt = ST_WR;
      end
      ST_WR: begin
        ram_we = 1'b1;
        if (wrd_r == hi_word) begin
          out_valid_nxt = 1'b1;
          out_ok_nxt    = 1'b1;
          out_base_nxt  = set_r ? 12'(lo_r) : '0;
          state_nxt     = ST_IDLE;
        end else begin
          wrd_nxt   = wrd_r + AW'(1);
          state_nxt = ST_RD;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_CLEAR;
      clr_r       <= '0;
      ss_r        <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      clr_r       <= clr_nxt;
      ss_r        <= ss_nxt;
      out_valid_r <= out_valid_nxt;
    end
    cur_r      <= cur_nxt;
    wrd_r      <= wrd_nxt;
    carry_r    <= carry_nxt;
    cnt_r      <= cnt_nxt;
    lo_r       <= lo_nxt;
    hi_r       <= hi_nxt;
    set_r      <= set_nxt;
    out_ok_r   <= out_ok_nxt;
    out_base_r <= out_base_nxt;
  end

  assign busy           = (state_r != ST_IDLE);
  assign cfg_ready      = 1'b1;
  assign out_valid      = out_valid_r;
  assign out_ok         = out_ok_r;
  assign out_base_frame = out_base_r;

  `BFA_ASSERT_IMP(a_strobe_idle, out_valid, !busy, "result word while busy")
  `BFA_ASSERT_NXT(a_accept_moves, start && !busy, busy || out_valid,
                  "accepted word neither worked on nor answered")
  `BFA_ASSERT_IMP(a_fail_base_zero, out_valid && !out_ok, out_base_frame == '0,
                  "failed word carries a nonzero base")
  `BFA_ASSERT_IMP(a_upd_in_range, state_r == ST_WR, wrd_r <= hi_word,
                  "update walked past the last word of the run")

endmodule
